// ----- src/assert_macros.svh -----
// assertion macros used by the merge sort engine core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication checked from one edge to the next outside reset
`define MSE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- src/mse_pkg.sv -----
// types and constants of the merge sort engine
package mse_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] in_value;
    logic                    in_last;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_value;
    logic                    out_last;
    logic                    overflow;
  } out_word_t;

  // control of the ping-pong buffer pair
  typedef struct packed {
    logic we;    // write enable
    logic wr_b;  // write goes to buffer b
    logic rd_b;  // reads come from buffer b
  } buf_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT
  } state_e;

endpackage

// ----- src/mse_pingpong.sv -----
// ping-pong buffer pair: one write port, two registered read ports
module mse_pingpong import mse_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  buf_ctrl_t                    ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [DataW-1:0]             wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_l_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_r_i,
  output logic [DataW-1:0]             rd_data_l_o,
  output logic [DataW-1:0]             rd_data_r_o
);

  logic [DataW-1:0] mem_a [DEPTH];
  logic [DataW-1:0] mem_b [DEPTH];

  logic [DataW-1:0] a_l_q, a_r_q, b_l_q, b_r_q;
  logic             rd_b_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we && !ctrl_i.wr_b) begin
      mem_a[wr_addr_i] <= wr_data_i;
    end
    a_l_q <= mem_a[rd_addr_l_i];
    a_r_q <= mem_a[rd_addr_r_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we && ctrl_i.wr_b) begin
      mem_b[wr_addr_i] <= wr_data_i;
    end
    b_l_q <= mem_b[rd_addr_l_i];
    b_r_q <= mem_b[rd_addr_r_i];
  end

  // select is registered alongside the read data
  always_ff @(posedge clk_i) begin
    rd_b_q <= ctrl_i.rd_b;
  end

  assign rd_data_l_o = rd_b_q ? b_l_q : a_l_q;
  assign rd_data_r_o = rd_b_q ? b_r_q : a_r_q;

endmodule

// ----- src/merge_sort_engine_core.sv -----
// top level of the merge sort engine
//
// input channel (in_valid_i / in_ready_o / in_word_i): one signed 32-bit
// word per handshake; in_last closes the set. words beyond DEPTH are
// dropped and the overflow bit is raised on every output word of that set.
// output channel (out_valid_o / out_ready_i / out_word_o): the set in
// ascending order, one word per handshake, out_last on the final word.
// phases of a set of n words (n <= DEPTH):
//   load: input ready only while loading, and words may arrive back to back
//   sort: ceil(log2(n)) merge passes over the whole set, one write per cycle
//         into the destination buffer; a turnaround state before each
//         pass and before emit covers the buffer read latency
//   emit: one word per cycle while the receiver takes them
// a receiver stall freezes the emit pointer; the output register holds its
// word until taken. reset empties the set and clears overflow; buffer
// contents are not cleared since only words of the current set are read.
// the next set is accepted as soon as the final word enters the output
// register.
module merge_sort_engine_core import mse_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(DEPTH);     // buffer address
  localparam int unsigned CW = $clog2(DEPTH + 1); // counts up to DEPTH
  localparam int unsigned WW = CW + 1;            // run width, may pass DEPTH
  localparam int unsigned EW = CW + 2;            // run bounds before clamping

  // sequencer state
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;   // words loaded so far
  logic          ovf_q, ovf_d;       // a word of this set was dropped
  logic [CW-1:0] n_q, n_d;           // size of the set being sorted
  logic [WW-1:0] width_q, width_d;   // current run width
  logic          src_b_q, src_b_d;   // sorted data currently in buffer b
  logic [CW-1:0] i_q, i_d;           // left run head, also emit pointer
  logic [CW-1:0] j_q, j_d;           // right run head
  logic [CW-1:0] mid_q, mid_d;       // end of left run
  logic [CW-1:0] hi_q, hi_d;         // end of right run
  logic [CW-1:0] k_q, k_d;           // merge write pointer

  // output register
  logic          out_valid_q, out_valid_d;
  out_word_t     out_word_q, out_word_d;

  // buffer interface
  buf_ctrl_t        buf_ctrl;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;
  logic [DataW-1:0] rd_l, rd_r;

  // merge decisions
  logic          in_acc;
  logic          take_l;
  logic [CW-1:0] k_inc;
  logic          pair_end;
  logic          pass_end;
  logic [WW-1:0] width_nx;
  logic [CW-1:0] setup_lo;
  logic [EW-1:0] setup_mid_e, setup_hi_e;
  logic [CW-1:0] setup_mid, setup_hi;
  logic [CW-1:0] load_n;
  logic          emit_pop;
  logic          emit_last;

  assign in_acc   = in_valid_i && in_ready_o;
  assign k_inc    = k_q + CW'(1);
  assign pair_end = (k_inc == hi_q);
  assign pass_end = pair_end && (hi_q == n_q);

  // left wins when strictly smaller or the right run is used up, ties go to the right run
  assign take_l = (i_q < mid_q) &&
                  ((j_q >= hi_q) || ($signed(rd_l) < $signed(rd_r)));

  // bounds of the next pair of runs, clamped to the set size
  assign width_nx    = pass_end ? (width_q << 1) : width_q;
  assign setup_lo    = pass_end ? '0 : hi_q;
  assign setup_mid_e = EW'(setup_lo) + EW'(width_nx);
  assign setup_hi_e  = setup_mid_e + EW'(width_nx);
  assign setup_mid   = (setup_mid_e > EW'(n_q)) ? n_q : setup_mid_e[CW-1:0];
  assign setup_hi    = (setup_hi_e > EW'(n_q)) ? n_q : setup_hi_e[CW-1:0];

  // set size once the closing word is in
  assign load_n = (count_q < CW'(DEPTH)) ? (count_q + CW'(1)) : count_q;

  assign emit_pop  = !out_valid_q || out_ready_i;
  assign emit_last = ((i_q + CW'(1)) == n_q);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    width_d     = width_q;
    src_b_d     = src_b_q;
    i_d         = i_q;
    j_d         = j_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    buf_ctrl    = '0;
    wr_addr     = count_q[AW-1:0];
    wr_data     = in_word_i.in_value;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (count_q < CW'(DEPTH)) begin
            buf_ctrl.we = 1'b1;
            count_d     = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_word_i.in_last) begin
            // first pass merges runs of one word
            n_d     = load_n;
            width_d = WW'(1);
            src_b_d = 1'b0;
            i_d     = '0;
            mid_d   = CW'(1);
            j_d     = CW'(1);
            hi_d    = (load_n >= CW'(2)) ? CW'(2) : load_n;
            k_d     = '0;
            state_d = ST_PRIME;
          end
        end
      end

      // turnaround state: lets the read data of the new source arrive
      ST_PRIME: begin
        if (WW'(n_q) > width_q) begin
          state_d = ST_MERGE;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_MERGE: begin
        buf_ctrl.we   = 1'b1;
        buf_ctrl.wr_b = !src_b_q;
        wr_addr       = k_q[AW-1:0];
        wr_data       = take_l ? rd_l : rd_r;
        if (pair_end) begin
          i_d   = setup_lo;
          mid_d = setup_mid;
          j_d   = setup_mid;
          hi_d  = setup_hi;
          k_d   = setup_lo;
          if (pass_end) begin
            width_d = width_nx;
            src_b_d = !src_b_q;
            state_d = ST_PRIME;
          end
        end else begin
          k_d = k_inc;
          if (take_l) begin
            i_d = i_q + CW'(1);
          end else begin
            j_d = j_q + CW'(1);
          end
        end
      end

      ST_EMIT: begin
        if (emit_pop) begin
          out_valid_d          = 1'b1;
          out_word_d.out_value = $signed(rd_l);
          out_word_d.out_last  = emit_last;
          out_word_d.overflow  = ovf_q;
          if (emit_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // reads always target the next heads in the next source buffer
    buf_ctrl.rd_b = src_b_d;
  end

  mse_pingpong #(
    .DEPTH (DEPTH)
  ) u_buffers (
    .clk_i       (clk_i),
    .ctrl_i      (buf_ctrl),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_l_i (i_d[AW-1:0]),
    .rd_addr_r_i (j_d[AW-1:0]),
    .rd_data_l_o (rd_l),
    .rd_data_r_o (rd_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      width_q     <= '0;
      src_b_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      width_q     <= width_d;
      src_b_q     <= src_b_d;
      i_q         <= i_d;
      j_q         <= j_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word, no reset needed
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // fill level never passes the buffer size
  `MSE_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  // merge writes stay inside the current pair of runs
  `MSE_ASSERT(a_merge_in_pair, (state_q != ST_MERGE) || (k_q < hi_q))
  // emit pointer stays inside the set
  `MSE_ASSERT(a_emit_in_set, (state_q != ST_EMIT) || (i_q < n_q))
  // a stalled output word stays offered and unchanged until taken
  `MSE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_word_o))

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the merge sort engine core
module testbench;
  import mse_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int          IDLE_LIMIT = 5000;  // cycles without any handshake
  localparam int          TAIL       = 20;    // cycles watched after the last word
  localparam int          RAND_WORDS = 12;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  merge_sort_engine_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // sorter state as seen from outside: words of the open set and the drop flag
  logic signed [31:0] held_vals [DEPTH];
  int unsigned        held_count;
  logic               set_overflow;

  // sorted words still owed by the engine, oldest first
  out_word_t sorted_q [$];

  int errors;
  int words_in;
  int words_out;
  int sets_closed;
  int overflow_sets;
  int idle_cycles;
  int stall_left;
  bit gaps_on;

  // 20 time unit clock
  always #10 clk_i = ~clk_i;

  // gap length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mix of extremes, small values that collide, and full-range values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // track one accepted input word; closing the set produces its sorted output
  function automatic void take_word(in_word_t w);
    logic signed [31:0] vals [DEPTH];
    logic signed [31:0] key;
    int                 i;
    int                 j;
    int                 n;
    out_word_t          o;
    if (held_count < DEPTH) begin
      held_vals[held_count] = w.in_value;
      held_count++;
    end else begin
      // set already full, the word is dropped
      set_overflow = 1'b1;
    end
    if (w.in_last) begin
      n = held_count;
      for (i = 0; i < n; i++) vals[i] = held_vals[i];
      // ascending order on signed values
      for (i = 1; i < n; i++) begin
        key = vals[i];
        j   = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      for (i = 0; i < n; i++) begin
        o.out_value = vals[i];
        o.out_last  = (i == n - 1);
        o.overflow  = set_overflow;
        sorted_q.push_back(o);
      end
      sets_closed++;
      if (set_overflow) overflow_sets++;
      held_count   = 0;
      set_overflow = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 20) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    errors++;
  endtask

  // drive one word and hold it until the engine takes it
  task automatic send_word(input logic signed [31:0] v, input logic lst);
    in_word_t w;
    int       gap;
    w.in_value = v;
    w.in_last  = lst;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    take_word(w);
    words_in++;
    gap = gaps_on ? pick_gap() : 0;
    // with no gap, valid stays up for the next word
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_set(input int n);
    for (int k = 0; k < n; k++) send_word(pick_value(), k == n - 1);
  endtask

  // one-word sets at both ends of the range
  task automatic test_single();
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7fff_ffff, 1'b1);
  endtask

  // extremes, neighbors of the extremes and values around zero in one set
  task automatic test_extremes();
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(32'sh8000_0001, 1'b0);
    send_word(32'sh7fff_fffe, 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh8000_0000, 1'b1);
  endtask

  // presorted, reversed and all-equal sets
  task automatic test_order();
    for (int k = 0; k < 4; k++) send_word(k * 1000 - 1500, k == 3);
    for (int k = 0; k < 4; k++) send_word(1500 - k * 1000, k == 3);
    for (int k = 0; k < 4; k++) send_word(-7, k == 3);
  endtask

  // a set that exactly fills the buffer, then one that spills past it;
  // the closing word of the spilled set is itself dropped
  task automatic test_capacity();
    send_set(DEPTH);
    gaps_on = 1'b0;
    send_set(DEPTH + 1);
    gaps_on = 1'b1;
  endtask

  // short random sets, with and without gaps
  task automatic test_random_sets();
    int start;
    int n;
    start = words_in;
    while (words_in - start < RAND_WORDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 16);
      if (n > RAND_WORDS - (words_in - start)) n = RAND_WORDS - (words_in - start);
      send_set(n);
    end
    gaps_on = 1'b1;
  endtask

  // receiver: random stalls while gaps are on, otherwise always ready
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (gaps_on) stall_left = pick_gap();
    end
  end

  // compare each taken output word with the oldest sorted word owed
  always @(posedge clk_i) begin : check_out
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected word, value", out_word_o.out_value, 0);
      end else begin
        want = sorted_q.pop_front();
        if (out_word_o.out_value !== want.out_value)
          report_mismatch("out_value", out_word_o.out_value, want.out_value);
        if (out_word_o.out_last !== want.out_last)
          report_mismatch("out_last", out_word_o.out_last, want.out_last);
        if (out_word_o.overflow !== want.overflow)
          report_mismatch("overflow", out_word_o.overflow, want.overflow);
      end
    end
  end

  // watchdog: too long without a handshake on either side ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    out_ready_i   = 1'b0;
    held_count    = 0;
    set_overflow  = 1'b0;
    errors        = 0;
    words_in      = 0;
    words_out     = 0;
    sets_closed   = 0;
    overflow_sets = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    gaps_on       = 1'b1;

    // reset held low at the start, then released
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single();
    test_extremes();
    test_order();
    test_capacity();
    test_random_sets();

    // stop sending, then let every owed word come out
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (sorted_q.size() != 0) report_mismatch("words never emitted", sorted_q.size(), 0);

    $display("summary: %0d words loaded in %0d sets, %0d of them over capacity",
             words_in, sets_closed, overflow_sets);
    $display("summary: %0d sorted words checked with random gaps on both sides",
             words_out);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
